// ----- design/r2fft_pkg.sv -----
// Shared package of the radix-2 FFT engine: codes, default sizes, the
// butterfly control struct, saturation helpers and the twiddle generator.
// Used by the twiddle ROM, the butterfly, the top level and the bench; depends on nothing.
package r2fft_pkg;

  localparam int MAX_POINTS_DEF   = 1024;
  localparam int TWIDDLE_BITS_DEF = 18;

  localparam logic CFG_INVERSE = 1'b0;
  localparam logic CFG_LOG     = 1'b1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic ST_VALID = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;

  typedef struct packed {
    logic ld_x;
    logic ld_w;
    logic ld_u;
    logic mul_en;
    logic t_en;
  } bf_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [27:0] sat28(input logic signed [31:0] v);
    logic signed [27:0] r;
    if (v > 32'sd134217727) r = 28'sh7FFFFFF;
    else if (v < -32'sd134217728) r = 28'sh8000000;
    else r = v[27:0];
    return r;
  endfunction

  // Elaboration-time only: {cos, sin} of phase p / 2^32 turns at twiddle scale.
  function automatic logic [63:0] twiddle_pair(input logic [31:0] p, input int tbits);
    logic [2:0]  oct;
    logic [63:0] r, x, x2, ts, tc, ss, cs, a, b, ra, rb;
    logic [31:0] wc, ws;
    int          sh;
    oct = p[31:29];
    r   = {35'd0, p[28:0]};
    if (oct[0]) r = 64'h20000000 - r;
    x  = (r * TWO_PI_Q30 + 64'h80000000) >> 32;
    x2 = (x * x) >> 30;
    ts = x;
    tc = ONE_Q30;
    ss = x;
    cs = ONE_Q30;
    for (int k = 1; k <= 8; k++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k[0]) begin
        ss = ss - ts;
        cs = cs - tc;
      end else begin
        ss = ss + ts;
        cs = cs + tc;
      end
    end
    a  = (ss > ONE_Q30) ? ONE_Q30 : ss;
    b  = (cs > ONE_Q30) ? ONE_Q30 : cs;
    sh = 32 - tbits;
    ra = a;
    rb = b;
    if (sh > 0) begin
      ra = (a + (64'd1 << (sh - 1))) >> sh;
      rb = (b + (64'd1 << (sh - 1))) >> sh;
    end
    case (oct)
      3'd0: begin wc = rb[31:0];         ws = ra[31:0];         end
      3'd1: begin wc = ra[31:0];         ws = rb[31:0];         end
      3'd2: begin wc = 32'(64'd0 - ra);  ws = rb[31:0];         end
      3'd3: begin wc = 32'(64'd0 - rb);  ws = ra[31:0];         end
      3'd4: begin wc = 32'(64'd0 - rb);  ws = 32'(64'd0 - ra);  end
      3'd5: begin wc = 32'(64'd0 - ra);  ws = 32'(64'd0 - rb);  end
      3'd6: begin wc = ra[31:0];         ws = 32'(64'd0 - rb);  end
      default: begin wc = rb[31:0];      ws = 32'(64'd0 - ra);  end
    endcase
    return {wc, ws};
  endfunction

endpackage

// ----- design/r2fft_store.sv -----
// Point store of the FFT engine: one write port, one read port, read data
// registered. Depends on nothing.
module r2fft_store #(
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [63:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [63:0]       rdata
);

  logic [63:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/r2fft_twiddle.sv -----
// Twiddle ROM of the FFT engine: cos and sin of idx / 2^LMAX turns,
// built at elaboration, read registered. Depends on r2fft_pkg.
module r2fft_twiddle import r2fft_pkg::*; #(
  parameter int TB   = TWIDDLE_BITS_DEF,
  parameter int LMAX = 10,
  parameter int AW   = 9
) (
  input  logic                 clk,
  input  logic [AW-1:0]        addr,
  output logic signed [TB-1:0] w_cos,
  output logic signed [TB-1:0] w_sin
);

  logic [2*TB-1:0] rom [2**AW];

  for (genvar g = 0; g < 2**AW; g++) begin : g_rom
    localparam logic [63:0] E = twiddle_pair(32'(g) << (32 - LMAX), TB);
    assign rom[g] = {E[32+TB-1:32], E[TB-1:0]};
  end

  always_ff @(posedge clk) begin
    {w_cos, w_sin} <= rom[addr];
  end

endmodule

// ----- design/r2fft_butterfly.sv -----
// Butterfly datapath of the FFT engine: twiddle product with half-up rounding,
// then saturated sum and difference. Depends on r2fft_pkg.
module r2fft_butterfly import r2fft_pkg::*; #(
  parameter int TB = TWIDDLE_BITS_DEF
) (
  input  logic                 clk,
  input  bf_ctl_t              ctl,
  input  logic                 inv,
  input  logic [63:0]          rd_data,
  input  logic signed [TB-1:0] w_cos,
  input  logic signed [TB-1:0] w_sin,
  output logic [63:0]          sum_data,
  output logic [63:0]          diff_data
);

  localparam int FB = TB - 2;
  localparam int PW = TB + 32;
  localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (FB - 1);

  logic signed [TB-1:0] w_re, w_im;
  logic signed [31:0]   x_re, x_im, u_re, u_im;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [34:0]   t_re, t_im;
  logic signed [PW:0]   tr_full, ti_full;
  logic signed [PW:0]   tr_sh, ti_sh;

  always_ff @(posedge clk) begin
    if (ctl.ld_x) begin
      x_re <= rd_data[31:0];
      x_im <= rd_data[63:32];
    end
    if (ctl.ld_w) begin
      w_re <= w_cos;
      w_im <= inv ? w_sin : -w_sin;
    end
    if (ctl.ld_u) begin
      u_re <= rd_data[31:0];
      u_im <= rd_data[63:32];
    end
    if (ctl.mul_en) begin
      p_rr <= w_re * x_re;
      p_ii <= w_im * x_im;
      p_ri <= w_re * x_im;
      p_ir <= w_im * x_re;
    end
    if (ctl.t_en) begin
      t_re <= tr_sh[34:0];
      t_im <= ti_sh[34:0];
    end
  end

  always_comb begin
    tr_full = (PW+1)'(p_rr) - (PW+1)'(p_ii) + HALF;
    ti_full = (PW+1)'(p_ri) + (PW+1)'(p_ir) + HALF;
    tr_sh   = tr_full >>> FB;
    ti_sh   = ti_full >>> FB;
  end

  assign sum_data  = {sat32(36'(u_im) + 36'(t_im)), sat32(36'(u_re) + 36'(t_re))};
  assign diff_data = {sat32(36'(u_im) - 36'(t_im)), sat32(36'(u_re) - 36'(t_re))};

endmodule

// ----- design/radix2_fft_engine.sv -----
// Radix-2 decimation-in-time FFT of 2^log_size points (log_size clamped to 1..log2(MAX_POINTS)).
// Push beats write samples in bit-reversed order, one per cycle while idle and output not held;
// the last sample (or a full frame) starts the transform: zero padding of missing points, one per
// cycle, then (n/2)*log2(n) butterflies (read B, read A, multiply, sum products, write A, write B)
// through the single store, then in forward mode a 1/n scaling pass, reading and writing each point.
// A pull while a frame is ready goes through the pull state; with none ready an empty beat returns.
// Depends on r2fft_pkg, r2fft_store, r2fft_twiddle, r2fft_butterfly.
module radix2_fft_engine import r2fft_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_real, sample_imag
  input  logic        s_tuser,   // operation
  input  logic        s_tlast,   // last_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_real, out_imag
  output logic        m_tuser,   // status
  output logic        m_tlast,   // last_out
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int LOG_W  = $clog2(ADDR_W + 1);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int TW_AW  = (ADDR_W > 1) ? ADDR_W - 1 : 1;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_PULL   = 12'b000000000010,
    S_PAD    = 12'b000000000100,
    S_BF_RDB = 12'b000000001000,
    S_BF_RDA = 12'b000000010000,
    S_BF_MUL = 12'b000000100000,
    S_BF_TW  = 12'b000001000000,
    S_BF_WRA = 12'b000010000000,
    S_BF_WRB = 12'b000100000000,
    S_SC_RD  = 12'b001000000000,
    S_SC_WR  = 12'b010000000000,
    S_SPARE  = 12'b100000000000
  } state_t;

  state_t             state;
  logic               inverse_mode;
  logic [3:0]         log_size;
  logic               frame_inv;
  logic [LOG_W-1:0]   frame_log;
  logic [LOG_W-1:0]   stage;
  logic [CNT_W-1:0]   load_count;
  logic [ADDR_W-1:0]  read_count;
  logic [CNT_W-1:0]   idx;
  logic               frame_ready;

  logic               accept;
  logic               empty_pull;
  logic [LOG_W-1:0]   eff_log, cur_log;
  logic [CNT_W-1:0]   n_pts, cur_n, next_cnt;
  logic [ADDR_W-1:0]  hmask, bidx, ia, ib;
  logic [TW_AW-1:0]   tw_addr;
  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [63:0]        wdata, rdata, sum_data, diff_data;
  logic signed [TWIDDLE_BITS-1:0] w_cos, w_sin;
  bf_ctl_t            ctl;
  logic               bf_last, stage_last;
  logic signed [31:0] sc_re, sc_im;

  function automatic logic [ADDR_W-1:0] brev(input logic [ADDR_W-1:0] v,
                                             input logic [LOG_W-1:0] l);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) begin
      r[i] = v[ADDR_W-1-i];
    end
    return r >> (LOG_W'(ADDR_W) - l);
  endfunction

  always_comb begin
    if (log_size == 4'd0) eff_log = LOG_W'(1);
    else if (int'(log_size) > ADDR_W) eff_log = LOG_W'(ADDR_W);
    else eff_log = LOG_W'(log_size);
  end

  assign s_tready   = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign empty_pull = accept && (s_tuser == OP_PULL) && !frame_ready;
  assign cur_log    = (load_count == '0) ? eff_log : frame_log;
  assign cur_n      = CNT_W'(1) << cur_log;
  assign n_pts      = CNT_W'(1) << frame_log;
  assign next_cnt   = load_count + CNT_W'(1);

  assign hmask      = (ADDR_W'(1) << (stage - LOG_W'(1))) - ADDR_W'(1);
  assign bidx       = idx[ADDR_W-1:0];
  assign ia         = ((bidx & ~hmask) << 1) | (bidx & hmask);
  assign ib         = ia | (hmask + ADDR_W'(1));
  assign tw_addr    = TW_AW'((bidx & hmask) << (LOG_W'(ADDR_W) - stage));
  assign bf_last    = idx == ((n_pts >> 1) - CNT_W'(1));
  assign stage_last = stage == frame_log;
  assign sc_re      = $signed(rdata[31:0]) >>> frame_log;
  assign sc_im      = $signed(rdata[63:32]) >>> frame_log;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    ctl   = '0;
    unique case (state)
      S_IDLE: begin
        raddr = read_count;
        if (accept && s_tuser == OP_PUSH) begin
          we    = 1'b1;
          waddr = brev(load_count[ADDR_W-1:0], cur_log);
          wdata = {{16{s_tdata[31]}}, s_tdata[31:16], {16{s_tdata[15]}}, s_tdata[15:0]};
        end
      end
      S_PAD: begin
        we    = 1'b1;
        waddr = brev(idx[ADDR_W-1:0], frame_log);
      end
      S_BF_RDB: raddr = ib;
      S_BF_RDA: begin
        raddr      = ia;
        ctl.ld_x   = 1'b1;
        ctl.ld_w   = 1'b1;
      end
      S_BF_MUL: begin
        ctl.ld_u   = 1'b1;
        ctl.mul_en = 1'b1;
      end
      S_BF_TW: ctl.t_en = 1'b1;
      S_BF_WRA: begin
        we    = 1'b1;
        waddr = ia;
        wdata = sum_data;
      end
      S_BF_WRB: begin
        we    = 1'b1;
        waddr = ib;
        wdata = diff_data;
      end
      S_SC_RD: raddr = idx[ADDR_W-1:0];
      S_SC_WR: begin
        we    = 1'b1;
        waddr = idx[ADDR_W-1:0];
        wdata = {sc_im, sc_re};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
      log_size     <= 4'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INVERSE: inverse_mode <= cfg_data[0];
        CFG_LOG:     log_size     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_log   <= LOG_W'(1);
      frame_inv   <= 1'b0;
      stage       <= LOG_W'(1);
      load_count  <= '0;
      read_count  <= '0;
      idx         <= '0;
      frame_ready <= 1'b0;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
      m_tuser     <= ST_VALID;
      m_tlast     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !empty_pull) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && s_tuser == OP_PUSH) begin
            frame_ready <= 1'b0;
            read_count  <= '0;
            frame_log   <= cur_log;
            if (s_tlast || next_cnt == cur_n) begin
              frame_inv  <= inverse_mode;
              load_count <= '0;
              stage      <= LOG_W'(1);
              if (next_cnt == cur_n) begin
                idx   <= '0;
                state <= S_BF_RDB;
              end else begin
                idx   <= next_cnt;
                state <= S_PAD;
              end
            end else begin
              load_count <= next_cnt;
            end
          end else if (accept) begin
            if (frame_ready) begin
              state <= S_PULL;
            end else begin
              m_tvalid <= 1'b1;
              m_tdata  <= '0;
              m_tlast  <= 1'b0;
              m_tuser  <= ST_EMPTY;
            end
          end
        end
        S_PULL: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {sat28($signed(rdata[63:32])), sat28($signed(rdata[31:0]))};
          m_tuser  <= ST_VALID;
          m_tlast  <= read_count == ADDR_W'(n_pts - CNT_W'(1));
          if (read_count == ADDR_W'(n_pts - CNT_W'(1))) begin
            frame_ready <= 1'b0;
            read_count  <= '0;
          end else begin
            read_count <= read_count + ADDR_W'(1);
          end
          state <= S_IDLE;
        end
        S_PAD: begin
          if (idx == n_pts - CNT_W'(1)) begin
            idx   <= '0;
            state <= S_BF_RDB;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_BF_RDB: state <= S_BF_RDA;
        S_BF_RDA: state <= S_BF_MUL;
        S_BF_MUL: state <= S_BF_TW;
        S_BF_TW:  state <= S_BF_WRA;
        S_BF_WRA: state <= S_BF_WRB;
        S_BF_WRB: begin
          if (bf_last) begin
            idx <= '0;
            if (!stage_last) begin
              stage <= stage + LOG_W'(1);
              state <= S_BF_RDB;
            end else if (frame_inv) begin
              frame_ready <= 1'b1;
              state       <= S_IDLE;
            end else begin
              state <= S_SC_RD;
            end
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_BF_RDB;
          end
        end
        S_SC_RD: state <= S_SC_WR;
        S_SC_WR: begin
          if (idx == n_pts - CNT_W'(1)) begin
            idx         <= '0;
            frame_ready <= 1'b1;
            state       <= S_IDLE;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_SC_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  r2fft_store #(.ADDR_W(ADDR_W)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  r2fft_twiddle #(.TB(TWIDDLE_BITS), .LMAX(ADDR_W), .AW(TW_AW)) u_twiddle (
    .clk   (clk),
    .addr  (tw_addr),
    .w_cos (w_cos),
    .w_sin (w_sin)
  );

  r2fft_butterfly #(.TB(TWIDDLE_BITS)) u_butterfly (
    .clk       (clk),
    .ctl       (ctl),
    .inv       (frame_inv),
    .rd_data   (rdata),
    .w_cos     (w_cos),
    .w_sin     (w_sin),
    .sum_data  (sum_data),
    .diff_data (diff_data)
  );

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register lost its one-hot code");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD || state == S_BF_RDB || state == S_BF_WRB || state == S_SC_WR)
      |-> !frame_ready)
    else $error("frame marked ready while the transform runs");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata == '0 && !m_tlast))
    else $error("empty pull beat carries data");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    frame_ready |-> ({1'b0, read_count} < n_pts))
    else $error("read pointer beyond frame length");
`endif

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for radix2_fft_engine: directed table, then random frames over
// several size and direction settings, checked beat by beat against a behavioural FFT.
// Depends on r2fft_pkg and radix2_fft_engine only.
`timescale 1ns / 1ps

module tb;
  import r2fft_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] re;
    logic [15:0] im;
    logic        last;
  } beat_t;

  typedef struct {
    int   re;
    int   im;
    logic last;
    logic st;
  } fft_out_t;

  typedef struct {
    logic        op;
    logic [15:0] re;
    logic [15:0] im;
    logic        last;
    bit          fixed;
    int          ere;
    int          eim;
    logic        elast;
    logic        est;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [3:0]  cfg_data;

  radix2_fft_engine i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // behavioural engine state
  int          pt_re [1024];
  int          pt_im [1024];
  int          load_cnt;
  int          read_cnt;
  bit          ready_flag;
  int          frame_lg;
  bit          mode_inv;
  int          mode_lg;

  fft_out_t    fft_results_q [$];
  int          errors;
  int          beats_sent;
  int          beats_seen;
  int          frames_done;
  int          phases_run;

  function automatic int eff_log(input int lg);
    int r;
    r = lg;
    if (r < 1) r = 1;
    if (r > 10) r = 10;
    return r;
  endfunction

  function automatic int bit_rev(input int v, input int nb);
    int r;
    r = 0;
    for (int b = 0; b < nb; b++) r = (r << 1) | ((v >> b) & 1);
    return r;
  endfunction

  function automatic longint clip32(input longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    if (v < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic int clip28(input int v);
    int r;
    r = v;
    if (v > 134217727) r = 134217727;
    if (v < -134217728) r = -134217728;
    return r;
  endfunction

  function automatic void sin_cos_q30(input logic [63:0] x, output logic [63:0] s,
                                      output logic [63:0] c);
    logic [63:0] x2, ts, tc, ss, cs;
    x2 = (x * x) >> 30;
    ts = x;
    tc = ONE_Q30;
    ss = x;
    cs = ONE_Q30;
    for (int k = 1; k <= 8; k++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss = ss - ts;
        cs = cs - tc;
      end else begin
        ss = ss + ts;
        cs = cs + tc;
      end
    end
    s = (ss > ONE_Q30) ? ONE_Q30 : ss;
    c = (cs > ONE_Q30) ? ONE_Q30 : cs;
  endfunction

  function automatic void phase_rot(input logic [31:0] p, output longint wc,
                                    output longint ws);
    logic [2:0]  oct;
    logic [63:0] r, x, a, b;
    longint      ra, rb;
    oct = p[31:29];
    r = {35'd0, p[28:0]};
    if (oct[0]) r = 64'h20000000 - r;
    x = (r * TWO_PI_Q30 + 64'h80000000) >> 32;
    sin_cos_q30(x, a, b);
    ra = longint'((a + 64'd8192) >> 14);
    rb = longint'((b + 64'd8192) >> 14);
    case (oct)
      3'd0: begin wc = rb;  ws = ra;  end
      3'd1: begin wc = ra;  ws = rb;  end
      3'd2: begin wc = -ra; ws = rb;  end
      3'd3: begin wc = -rb; ws = ra;  end
      3'd4: begin wc = -rb; ws = -ra; end
      3'd5: begin wc = -ra; ws = -rb; end
      3'd6: begin wc = ra;  ws = -rb; end
      default: begin wc = rb; ws = -ra; end
    endcase
  endfunction

  function automatic void fft_transform();
    int          n, h, m, ia, ib;
    longint      wr, wi, xr, xi, tr, ti, ur, ui;
    logic [31:0] p;
    n = 1 << frame_lg;
    for (int i = load_cnt; i < n; i++) begin
      pt_re[bit_rev(i, frame_lg)] = 0;
      pt_im[bit_rev(i, frame_lg)] = 0;
    end
    for (int s = 1; s <= frame_lg; s++) begin
      m = 1 << s;
      h = m >> 1;
      for (int j = 0; j < h; j++) begin
        p = 32'(64'(j) << (32 - s));
        phase_rot(p, wr, wi);
        if (!mode_inv) wi = -wi;
        for (int k = 0; k < n; k += m) begin
          ia = k + j;
          ib = k + j + h;
          xr = pt_re[ib];
          xi = pt_im[ib];
          tr = (wr * xr - wi * xi + 64'sd32768) >>> 16;
          ti = (wr * xi + wi * xr + 64'sd32768) >>> 16;
          ur = pt_re[ia];
          ui = pt_im[ia];
          pt_re[ia] = int'(clip32(ur + tr));
          pt_im[ia] = int'(clip32(ui + ti));
          pt_re[ib] = int'(clip32(ur - tr));
          pt_im[ib] = int'(clip32(ui - ti));
        end
      end
    end
    if (!mode_inv) begin
      for (int i = 0; i < n; i++) begin
        pt_re[i] = pt_re[i] >>> frame_lg;
        pt_im[i] = pt_im[i] >>> frame_lg;
      end
    end
    frames_done++;
  endfunction

  // apply one accepted beat; returns 1 with the result a pull produces
  function automatic bit fft_accept(input beat_t b, output fft_out_t o);
    int n, a;
    o = '{0, 0, 1'b0, ST_EMPTY};
    if (b.op == OP_PUSH) begin
      if (ready_flag) begin
        ready_flag = 0;
        read_cnt = 0;
        load_cnt = 0;
      end
      if (load_cnt == 0) frame_lg = eff_log(mode_lg);
      n = 1 << frame_lg;
      a = bit_rev(load_cnt, frame_lg);
      pt_re[a] = int'($signed(b.re));
      pt_im[a] = int'($signed(b.im));
      load_cnt++;
      if (b.last || load_cnt >= n) begin
        fft_transform();
        ready_flag = 1;
        load_cnt = 0;
        read_cnt = 0;
      end
      return 0;
    end
    if (!ready_flag) return 1;
    n = 1 << frame_lg;
    a = read_cnt & (n - 1);
    o = '{clip28(pt_re[a]), clip28(pt_im[a]), logic'(a == n - 1), ST_VALID};
    if (a == n - 1) begin
      ready_flag = 0;
      read_cnt = 0;
    end else begin
      read_cnt = a + 1;
    end
    return 1;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL radix2_fft_engine");
    $finish;
  end

  task automatic send_beat(input beat_t b, input bit typed, input fft_out_t want);
    fft_out_t o;
    int       r, gap;
    s_tvalid <= 1'b1;
    s_tuser  <= b.op;
    s_tdata  <= {b.im, b.re};
    s_tlast  <= b.last;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    if (fft_accept(b, o)) fft_results_q.push_back(typed ? want : o);
    r = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 88) ? $urandom_range(1, 3) :
          (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_mode(input bit inv, input int lg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INVERSE;
    cfg_data  <= {3'd0, inv};
    @(posedge clk);
    cfg_index <= CFG_LOG;
    cfg_data  <= 4'(lg);
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_inv = inv;
    mode_lg = lg;
  endtask

  task automatic drain_idle();
    s_tvalid <= 1'b0;
    while (fft_results_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r == 2) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic random_frames(input int budget, input bit read_all);
    beat_t    b;
    fft_out_t none;
    int       n, k, pulls, used, r;
    none = '{0, 0, 1'b0, ST_EMPTY};
    used = 0;
    n = 1 << eff_log(mode_lg);
    while (used < budget) begin
      k = (n > 64) ? $urandom_range(1, 4) :
          ($urandom_range(0, 2) == 0) ? $urandom_range(1, n) : n;
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          b = '{OP_PULL, 16'($urandom), 16'($urandom), 1'($urandom)};
          send_beat(b, 0, none);
          used++;
        end
        b = '{OP_PUSH, pick_sample(), pick_sample(), 1'b0};
        if (i == k - 1) b.last = (k < n) ? 1'b1 : 1'($urandom);
        else if (k < n && $urandom_range(0, 49) == 0) b.last = 1'b1;
        send_beat(b, 0, none);
        used++;
      end
      r = $urandom_range(0, 99);
      pulls = (n > 64) ? $urandom_range(0, 3) :
              (r < 70) ? n + $urandom_range(0, 1) :
              (r < 88) ? $urandom_range(0, n - 1) : $urandom_range(0, 3);
      for (int i = 0; i < pulls; i++) begin
        b = '{OP_PULL, 16'($urandom), 16'($urandom), 1'($urandom)};
        send_beat(b, 0, none);
        used++;
      end
    end
    while (ready_flag && (read_all || n <= 64)) begin
      b = '{OP_PULL, 16'($urandom), 16'($urandom), 1'b0};
      send_beat(b, 0, none);
    end
    b = '{OP_PULL, 16'($urandom), 16'($urandom), 1'b0};
    send_beat(b, 0, none);
  endtask

  row_t dir_tab [19];

  initial begin
    beat_t    b;
    fft_out_t w;
    bit       p_inv  [9];
    int       p_lg   [9];
    int       p_len  [9];
    bit       p_full [9];
    p_inv  = '{1, 0, 1, 0, 1, 0, 1, 0, 1};
    p_lg   = '{1, 3, 4, 5, 6, 0, 10, 15, 2};
    p_len  = '{30, 30, 30, 30, 20, 20, 3, 3, 30};
    p_full = '{1, 1, 1, 1, 1, 1, 1, 0, 1};
    dir_tab = '{
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 1, 0, 0, 1'b0, ST_EMPTY},
      '{OP_PUSH, 16'h0004, 16'hFFF8, 1'b1, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 1, 1, -2, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 1, 1, -2, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 1, 1, -2, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b1, 1, 1, -2, 1'b1, ST_VALID},
      '{OP_PULL, 16'hFFFF, 16'hFFFF, 1'b1, 1, 0, 0, 1'b0, ST_EMPTY},
      '{OP_PUSH, 16'h7FFF, 16'h8000, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PUSH, 16'h8000, 16'h7FFF, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PUSH, 16'h0001, 16'hFFFF, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PUSH, 16'h0000, 16'h0000, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PUSH, 16'h0064, 16'h00C8, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PUSH, 16'h7FFF, 16'h7FFF, 1'b1, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 0, 0, 0, 1'b0, ST_VALID},
      '{OP_PULL, 16'h0000, 16'h0000, 1'b0, 1, 0, 0, 1'b0, ST_EMPTY}
    };
    errors = 0;
    beats_sent = 0;
    frames_done = 0;
    phases_run = 0;
    load_cnt = 0;
    read_cnt = 0;
    ready_flag = 0;
    frame_lg = 1;
    mode_inv = 0;
    mode_lg = 10;
    for (int i = 0; i < 1024; i++) begin
      pt_re[i] = 0;
      pt_im[i] = 0;
    end
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_INVERSE;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // first row runs at reset settings, the rest at four points forward
    b = '{dir_tab[0].op, dir_tab[0].re, dir_tab[0].im, dir_tab[0].last};
    w = '{dir_tab[0].ere, dir_tab[0].eim, dir_tab[0].elast, dir_tab[0].est};
    send_beat(b, 1, w);
    drain_idle();
    set_mode(0, 2);
    for (int i = 1; i < 19; i++) begin
      b = '{dir_tab[i].op, dir_tab[i].re, dir_tab[i].im, dir_tab[i].last};
      w = '{dir_tab[i].ere, dir_tab[i].eim, dir_tab[i].elast, dir_tab[i].est};
      send_beat(b, dir_tab[i].fixed, w);
    end
    drain_idle();
    for (int ph = 0; ph < 9; ph++) begin
      set_mode(p_inv[ph], p_lg[ph]);
      random_frames(p_len[ph], p_full[ph]);
      drain_idle();
      phases_run++;
    end
    $display("Covered %0d phases and %0d transforms: %0d input beats, %0d result beats.",
             phases_run + 1, frames_done, beats_sent, beats_seen);
    if (errors == 0) begin
      $display("PASS radix2_fft_engine");
    end else begin
      $display("FAIL radix2_fft_engine");
    end
    $finish;
  end

  // receiver: random back-pressure, steady stretches, and one long hold-off
  initial begin
    int  r;
    int  hold;
    bit  long_done;
    bit  steady;
    long_done = 0;
    steady = 0;
    m_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 149) == 0) steady = ~steady;
      if (!long_done && beats_seen >= 300) begin
        long_done = 1;
        m_tready <= 1'b0;
        hold = 600;
      end else if (steady || r < 60) begin
        m_tready <= 1'b1;
        hold = 1;
      end else begin
        m_tready <= 1'b0;
        hold = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      repeat (hold) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    fft_out_t e;
    int       gr, gi;
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      gr = int'($signed(m_tdata[27:0]));
      gi = int'($signed(m_tdata[55:28]));
      if (fft_results_q.size() == 0) begin
        $display("%0t: result beat with none expected: re %0d im %0d last %b status %b",
                 $time, gr, gi, m_tlast, m_tuser);
        errors++;
      end else begin
        e = fft_results_q.pop_front();
        if (gr != e.re || gi != e.im || m_tlast !== e.last || m_tuser !== e.st) begin
          $display("%0t: mismatch expected re %0d im %0d last %b status %b",
                   $time, e.re, e.im, e.last, e.st);
          $display("%0t:          actual   re %0d im %0d last %b status %b",
                   $time, gr, gi, m_tlast, m_tuser);
          errors++;
        end
      end
    end
  end

endmodule

// ----- files.f -----
design/r2fft_pkg.sv
design/r2fft_store.sv
design/r2fft_twiddle.sv
design/r2fft_butterfly.sv
design/radix2_fft_engine.sv
bench/tb.sv
